// File: hw/rtl/lom_pkg.sv
// Package for the limit order matcher: word types, book entry layout,
// status and kind codes, sequencer states and default sizes. No dependencies.
`default_nettype none

package lom_pkg;

  localparam int NUM_SYMBOLS_DEF = 4;
  localparam int BOOK_DEPTH_DEF  = 16;

  localparam int PRICE_W = 24;
  localparam int QTY_W   = 16;
  localparam int TRADER_W = 8;
  localparam int ARR_W   = 32;

  // result kinds
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // final order status codes
  localparam logic [1:0] STAT_REST    = 2'd0;
  localparam logic [1:0] STAT_PARTIAL = 2'd1;
  localparam logic [1:0] STAT_FILLED  = 2'd2;
  localparam logic [1:0] STAT_DROPPED = 2'd3;

  typedef struct packed {
    logic [1:0]          symbol_index;
    logic                side;
    logic [PRICE_W-1:0]  limit_price;
    logic [QTY_W-1:0]    order_qty;
    logic [TRADER_W-1:0] trader_id;
  } lom_in_t;

  typedef struct packed {
    logic                kind;
    logic [QTY_W-1:0]    trade_qty;
    logic [PRICE_W-1:0]  trade_price;
    logic [TRADER_W-1:0] buyer_id;
    logic [TRADER_W-1:0] seller_id;
    logic [1:0]          order_status;
    logic [QTY_W-1:0]    remaining_qty;
    logic                last;
  } lom_out_t;

  typedef struct packed {
    logic                valid;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    remaining;
    logic [TRADER_W-1:0] trader;
    logic [ARR_W-1:0]    arrival;
  } lom_entry_t;

  // control from the sequencer to the best-entry compare unit
  typedef struct packed {
    logic clr;
    logic eval;
  } lom_cmp_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MSCAN,
    S_MTRADE,
    S_FSCAN,
    S_INSERT,
    S_STAT
  } lom_state_t;

  // symbol index reduced modulo ns by repeated subtraction (value below 4)
  function automatic logic [1:0] sym_mod(input logic [1:0] v, input int ns);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (int'(r) >= ns) begin
        r = r - 2'(ns);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lom_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lom_cmp.sv
// Best-entry compare unit: takes one book entry per cycle and keeps the
// best eligible one by price, then age. Depends on lom_pkg.
`default_nettype none

module lom_cmp #(
  parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lom_pkg::lom_cmp_ctl_t    ctl,
  input  wire logic                     side,
  input  wire logic [23:0]              limit,
  input  wire logic [31:0]              now,
  input  wire lom_pkg::lom_entry_t      entry,
  input  wire logic [((BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1)-1:0] slot,
  output logic                          found,
  output logic [((BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1)-1:0] best_slot,
  output lom_pkg::lom_entry_t           best_entry
);
  import lom_pkg::*;

  localparam int SW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  logic              found_r;
  logic [SW-1:0]     best_slot_r;
  lom_entry_t        best_entry_r;
  logic [ARR_W-1:0]  best_age_r;
  logic [ARR_W-1:0]  age;
  logic              eligible;
  logic              better;

  always_comb begin
    age      = now - entry.arrival;
    eligible = entry.valid &&
               (side ? (entry.price >= limit) : (entry.price <= limit));
    if (!found_r) begin
      better = 1'b1;
    end else if (entry.price != best_entry_r.price) begin
      better = side ? (entry.price > best_entry_r.price)
                    : (entry.price < best_entry_r.price);
    end else begin
      better = age > best_age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
    end else if (ctl.eval && eligible && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && eligible && better) begin
      best_slot_r  <= slot;
      best_entry_r <= entry;
      best_age_r   <= age;
    end
  end

  assign found      = found_r;
  assign best_slot  = best_slot_r;
  assign best_entry = best_entry_r;

endmodule

`default_nettype wire

// File: hw/rtl/limit_order_matcher.sv
// Limit order matcher with price-time priority over NUM_SYMBOLS books.
// Top level: sequencer, book RAM and compare unit. Depends on lom_pkg,
// lom_ram and lom_cmp.
//
// Usage:
//   in_*  : one order word per accept (valid high, stall low). in_stall is
//           high while an order is being worked; the next order is taken
//           once the status word is in the output register.
//   out_* : zero or more trade words then one status word (last = 1) per
//           order. out_stall holds the output register and the sequencer
//           waits for it to free up before emitting the next word.
// Timing: a matching pass walks the opposite book one entry a cycle through
//   the RAM read port; a trade step follows a pass that found an entry. A
//   filled order takes a pass and a trade step per trade. A remainder adds
//   a pass that finds nothing (skipped after BOOK_DEPTH trades), a free-slot
//   walk that stops at the first free slot and an insert step. Output stalls
//   lengthen these sequences.
// Reset: books are cleared by a pass that writes every RAM entry, one a
//   cycle, NUM_SYMBOLS * 2 * BOOK_DEPTH entries (128 by default).
`default_nettype none

module limit_order_matcher #(
  parameter int NUM_SYMBOLS = lom_pkg::NUM_SYMBOLS_DEF,
  parameter int BOOK_DEPTH  = lom_pkg::BOOK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lom_pkg::lom_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lom_pkg::lom_out_t      out_data
);
  import lom_pkg::*;

  localparam int SLOT_COUNT = NUM_SYMBOLS * 2 * BOOK_DEPTH;
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int SW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int EW = $bits(lom_entry_t);

  lom_state_t        state_r, state_nxt;
  lom_in_t           ord_r;
  logic [AW-1:0]     opp_base_r, own_base_r;
  logic [ARR_W-1:0]  now_r, arr_cnt_r;
  logic [QTY_W-1:0]  rem_r;
  logic [CW-1:0]     ntr_r, cnt_r;
  logic              rd_pend_r;
  logic [SW-1:0]     rd_slot_r;
  logic              free_found_r;
  logic [SW-1:0]     free_slot_r;
  logic [1:0]        status_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  lom_out_t          out_data_r;

  logic [1:0]        sym;
  logic              accept;
  logic              out_free;
  logic              scan_done, fscan_done;
  logic [QTY_W-1:0]  tq, rem_after, entry_left;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  lom_entry_t        wr_entry, rd_entry;
  logic [EW-1:0]     rd_word;
  lom_cmp_ctl_t      cmp_ctl;
  logic              best_found;
  logic [SW-1:0]     best_slot;
  lom_entry_t        best_entry;
  logic              out_load;
  lom_out_t          out_word;
  logic [1:0]        ins_status;

  lom_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT)
  ) u_book (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_entry = lom_entry_t'(rd_word);

  lom_cmp #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .side       (ord_r.side),
    .limit      (ord_r.limit_price),
    .now        (now_r),
    .entry      (rd_entry),
    .slot       (rd_slot_r),
    .found      (best_found),
    .best_slot  (best_slot),
    .best_entry (best_entry)
  );

  assign sym        = sym_mod(in_data.symbol_index, NUM_SYMBOLS);
  assign accept     = (state_r == S_IDLE) && in_valid;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_done  = (cnt_r == CW'(BOOK_DEPTH)) && !rd_pend_r;
  assign fscan_done = (free_found_r || (cnt_r == CW'(BOOK_DEPTH))) && !rd_pend_r;

  assign tq         = (rem_r < best_entry.remaining) ? rem_r : best_entry.remaining;
  assign rem_after  = rem_r - tq;
  assign entry_left = best_entry.remaining - tq;
  assign ins_status = (rem_r < ord_r.order_qty) ? STAT_PARTIAL : STAT_REST;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.order_qty == '0) ? S_STAT : S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (scan_done) state_nxt = best_found ? S_MTRADE : S_FSCAN;
      end
      S_MTRADE: begin
        if (out_free) begin
          if (rem_after == '0) begin
            state_nxt = S_STAT;
          end else if (ntr_r + 1'b1 == CW'(BOOK_DEPTH)) begin
            state_nxt = S_FSCAN;
          end else begin
            state_nxt = S_MSCAN;
          end
        end
      end
      S_FSCAN: begin
        if (fscan_done) state_nxt = S_INSERT;
      end
      S_INSERT: state_nxt = S_STAT;
      S_STAT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_entry    = '0;
    cmp_ctl.clr = 1'b0;
    cmp_ctl.eval = 1'b0;
    out_load    = 1'b0;
    out_word    = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      S_IDLE: begin
        cmp_ctl.clr = in_valid;
      end
      S_MSCAN: begin
        rd_en        = (cnt_r != CW'(BOOK_DEPTH));
        rd_addr      = opp_base_r + AW'(cnt_r[SW-1:0]);
        cmp_ctl.eval = rd_pend_r;
      end
      S_MTRADE: begin
        cmp_ctl.clr = out_free;
        if (out_free) begin
          wr_en              = 1'b1;
          wr_addr            = opp_base_r + AW'(best_slot);
          wr_entry           = best_entry;
          wr_entry.valid     = (entry_left != '0);
          wr_entry.remaining = entry_left;
          out_load               = 1'b1;
          out_word.kind          = KIND_TRADE;
          out_word.trade_qty     = tq;
          out_word.trade_price   = best_entry.price;
          out_word.buyer_id      = ord_r.side ? best_entry.trader : ord_r.trader_id;
          out_word.seller_id     = ord_r.side ? ord_r.trader_id : best_entry.trader;
          out_word.order_status  = STAT_REST;
          out_word.remaining_qty = rem_after;
          out_word.last          = 1'b0;
        end
      end
      S_FSCAN: begin
        rd_en   = (cnt_r != CW'(BOOK_DEPTH)) && !free_found_r;
        rd_addr = own_base_r + AW'(cnt_r[SW-1:0]);
      end
      S_INSERT: begin
        wr_en    = free_found_r;
        wr_addr  = own_base_r + AW'(free_slot_r);
        wr_entry.valid     = 1'b1;
        wr_entry.price     = ord_r.limit_price;
        wr_entry.remaining = rem_r;
        wr_entry.trader    = ord_r.trader_id;
        wr_entry.arrival   = now_r;
      end
      S_STAT: begin
        out_load               = out_free;
        out_word.kind          = KIND_STATUS;
        out_word.order_status  = status_r;
        out_word.remaining_qty = rem_r;
        out_word.last          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      arr_cnt_r    <= '0;
      cnt_r        <= '0;
      rd_pend_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (accept) arr_cnt_r <= arr_cnt_r + 1'b1;
      // scan counter restarts on every state change
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (accept) begin
        free_found_r <= 1'b0;
      end else if (state_r == S_FSCAN && rd_pend_r && !free_found_r &&
                   !rd_entry.valid) begin
        free_found_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_slot_r <= cnt_r[SW-1:0];
    if (state_r == S_FSCAN && rd_pend_r && !free_found_r && !rd_entry.valid) begin
      free_slot_r <= rd_slot_r;
    end
    if (out_load) out_data_r <= out_word;
    if (accept) begin
      ord_r      <= in_data;
      now_r      <= arr_cnt_r;
      rem_r      <= in_data.order_qty;
      ntr_r      <= '0;
      status_r   <= STAT_FILLED;
      opp_base_r <= AW'((int'(sym) * 2 + int'(!in_data.side)) * BOOK_DEPTH);
      own_base_r <= AW'((int'(sym) * 2 + int'(in_data.side)) * BOOK_DEPTH);
    end
    if (state_r == S_MTRADE && out_free) begin
      rem_r <= rem_after;
      ntr_r <= ntr_r + 1'b1;
    end
    if (state_r == S_INSERT) begin
      status_r <= free_found_r ? ins_status : STAT_DROPPED;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
